>>> hw/rtl/deq_pkg.sv
`timescale 1ns / 1ps
// Shared codes and control/status types for the double-ended queue engine.
package deq_pkg;

    typedef logic [3:0] t_mode;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_cls;

    localparam t_mode MODE_PUSH_FRONT = 4'd0;
    localparam t_mode MODE_PUSH_BACK  = 4'd1;
    localparam t_mode MODE_POP_FRONT  = 4'd2;
    localparam t_mode MODE_POP_BACK   = 4'd3;
    localparam t_mode MODE_READ_FRONT = 4'd4;
    localparam t_mode MODE_READ_BACK  = 4'd5;
    localparam t_mode MODE_READ_AT    = 4'd6;
    localparam t_mode MODE_INSERT_AT  = 4'd7;
    localparam t_mode MODE_ERASE_AT   = 4'd8;
    localparam t_mode MODE_CLEAR      = 4'd9;

    localparam t_status STS_OK    = 2'd0;
    localparam t_status STS_FULL  = 2'd1;
    localparam t_status STS_RANGE = 2'd2;
    localparam t_status STS_EMPTY = 2'd3;

    // Follow-up work that an operation needs after its execute cycle
    localparam t_cls CLS_DONE  = 2'd0;
    localparam t_cls CLS_READ  = 2'd1;
    localparam t_cls CLS_SHIFT = 2'd2;
    localparam t_cls CLS_VAL   = 2'd3;

    typedef struct packed {
        logic capture;
        logic exec;
        logic rdcap;
        logic shift;
        logic drain;
        logic wrval;
        logic load;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic last;
        logic ins;
    } t_sts;

endpackage

>>> hw/rtl/double_ended_queue_engine.sv
`timescale 1ns / 1ps
// Top level of the double-ended queue engine: controller, datapath and checks.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  request  | i_valid / o_stall  | i_mode, i_position, i_item_value
//  result   | o_valid / i_stall  | o_read_value, o_status, o_count, o_is_empty
//
// Push, clear, rejected and unused operations run execute, then result; reads and pops
// add a read-wait step between them, set by the registered read of the store.
// An erase that moves n elements adds shift steps and a drain step (none when none move);
// an insert also writes the value; n <= DEPTH/2, one element per cycle through the store.
// Reset clears head, count and control; store contents are left as they are.
// A finished result waits in the output register while the next beat is taken;
// the engine holds its result step only while that register is occupied and stalled.
module double_ended_queue_engine #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_mode,
    input  logic [6:0]  i_position,
    input  logic [31:0] i_item_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_value,
    output logic [1:0]  o_status,
    output logic [6:0]  o_count,
    output logic        o_is_empty
);

    deq_pkg::t_cmd cmd;
    deq_pkg::t_sts sts;

    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_mode),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count),
        .o_is_empty   (o_is_empty)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("engine not busy after an accepted beat");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == deq_pkg::STS_FULL) |-> (o_count == 7'(DEPTH)))
        else $error("full status with count below capacity");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == deq_pkg::STS_EMPTY) |-> o_is_empty)
        else $error("empty status on a non-empty queue");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != deq_pkg::STS_OK) |-> (o_read_value == '0))
        else $error("rejected operation returned data");

endmodule

>>> hw/rtl/deq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/deq_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences execute, read wait, shift, drain, value write and result beats.
module deq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  deq_pkg::t_sts i_sts,
    output deq_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_RDWT  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_WRVAL = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_sts.cls)
                    deq_pkg::CLS_READ:  n_state = S_RDWT;
                    deq_pkg::CLS_SHIFT: n_state = S_SHIFT;
                    deq_pkg::CLS_VAL:   n_state = S_WRVAL;
                    default:            n_state = S_FIN;
                endcase
            end
            S_RDWT: begin
                o_cmd.rdcap = 1'b1;
                n_state     = S_FIN;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.drain = 1'b1;
                n_state     = i_sts.ins ? S_WRVAL : S_FIN;
            end
            S_WRVAL: begin
                o_cmd.wrval = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> hw/rtl/deq_dp.sv
`timescale 1ns / 1ps
// Datapath: ring store, head and count, operation decode, shift addressing, result registers.
module deq_dp #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  deq_pkg::t_cmd   i_cmd,
    output deq_pkg::t_sts   o_sts,
    input  logic [3:0]      i_mode,
    input  logic [6:0]      i_position,
    input  logic [31:0]     i_item_value,
    output logic [31:0]     o_read_value,
    output logic [1:0]      o_status,
    output logic [6:0]      o_count,
    output logic            o_is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int PW = (CW > 7) ? CW : 7;

    function automatic logic [AW-1:0] f_wrap(input logic [SW-1:0] x);
        logic [SW-1:0] t;
        t = (x >= SW'(DEPTH)) ? (x - SW'(DEPTH)) : x;
        return t[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : (a + AW'(1));
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(DEPTH - 1) : (a - AW'(1));
    endfunction

    deq_pkg::t_mode   r_mode;
    logic [6:0]       r_pos;
    logic [WIDTH-1:0] r_val;
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    n_head;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic             r_pend;
    logic             n_pend;
    logic [AW-1:0]    r_src;
    logic [AW-1:0]    r_dst;
    logic [AW-1:0]    r_vaddr;
    logic             r_up;
    logic [CW-1:0]    r_left;
    logic [1:0]       r_res_status;
    logic [31:0]      r_res_rd;
    logic [31:0]      r_out_rd;
    logic [1:0]       r_out_status;
    logic [6:0]       r_out_cnt;
    logic             r_out_empty;

    logic [PW-1:0]    p_ext;
    logic [PW-1:0]    c_ext;
    logic [PW:0]      p_dbl;
    logic [PW:0]      c_dbl;
    logic [CW-1:0]    pos_c;
    logic [SW-1:0]    h_s;
    logic [SW-1:0]    pos_s;
    logic [SW-1:0]    cnt_s;
    logic             full;
    logic             empty;
    logic             pos_ge;
    logic             pos_gt;
    logic             ins_front;
    logic             ers_front;
    logic [AW-1:0]    a_hm1;
    logic [AW-1:0]    a_hp1;
    logic [AW-1:0]    a_back;
    logic [AW-1:0]    a_last;
    logic [AW-1:0]    a_pos;
    logic [AW-1:0]    a_posm1;
    logic [AW-1:0]    a_posp1;

    deq_pkg::t_status e_status;
    deq_pkg::t_cls    e_cls;
    logic             e_wr;
    logic [AW-1:0]    e_wr_addr;
    logic             e_rd;
    logic [AW-1:0]    e_rd_addr;
    logic [AW-1:0]    e_head;
    logic [CW-1:0]    e_cnt;
    logic [AW-1:0]    e_src;
    logic             e_up;
    logic [CW-1:0]    e_left;
    logic [AW-1:0]    e_vaddr;

    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [WIDTH-1:0] ram_wr_data;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [WIDTH-1:0] ram_rd_data;

    assign p_ext     = PW'(r_pos);
    assign c_ext     = PW'(r_cnt);
    assign p_dbl     = {p_ext, 1'b0};
    assign c_dbl     = {1'b0, c_ext};
    assign pos_c     = p_ext[CW-1:0];
    assign h_s       = SW'(r_head);
    assign pos_s     = SW'(pos_c);
    assign cnt_s     = SW'(r_cnt);
    assign full      = (r_cnt == CW'(DEPTH));
    assign empty     = (r_cnt == '0);
    assign pos_ge    = (p_ext >= c_ext);
    assign pos_gt    = (p_ext > c_ext);
    assign ins_front = (p_dbl <= c_dbl);
    assign ers_front = (p_dbl < c_dbl);
    assign a_hm1     = f_dec(r_head);
    assign a_hp1     = f_inc(r_head);
    assign a_back    = f_wrap(h_s + cnt_s);
    assign a_last    = f_wrap(h_s + cnt_s - SW'(1));
    assign a_pos     = f_wrap(h_s + pos_s);
    assign a_posm1   = f_dec(a_pos);
    assign a_posp1   = f_inc(a_pos);

    always_comb begin
        e_status  = deq_pkg::STS_OK;
        e_cls     = deq_pkg::CLS_DONE;
        e_wr      = 1'b0;
        e_wr_addr = a_back;
        e_rd      = 1'b0;
        e_rd_addr = r_head;
        e_head    = r_head;
        e_cnt     = r_cnt;
        e_src     = r_head;
        e_up      = 1'b1;
        e_left    = '0;
        e_vaddr   = a_pos;
        case (r_mode)
            deq_pkg::MODE_PUSH_FRONT: begin
                if (full) begin
                    e_status = deq_pkg::STS_FULL;
                end else begin
                    e_wr      = 1'b1;
                    e_wr_addr = a_hm1;
                    e_head    = a_hm1;
                    e_cnt     = r_cnt + CW'(1);
                end
            end
            deq_pkg::MODE_PUSH_BACK: begin
                if (full) begin
                    e_status = deq_pkg::STS_FULL;
                end else begin
                    e_wr      = 1'b1;
                    e_wr_addr = a_back;
                    e_cnt     = r_cnt + CW'(1);
                end
            end
            deq_pkg::MODE_POP_FRONT: begin
                if (empty) begin
                    e_status = deq_pkg::STS_EMPTY;
                end else begin
                    e_rd      = 1'b1;
                    e_rd_addr = r_head;
                    e_cls     = deq_pkg::CLS_READ;
                    e_head    = a_hp1;
                    e_cnt     = r_cnt - CW'(1);
                end
            end
            deq_pkg::MODE_POP_BACK: begin
                if (empty) begin
                    e_status = deq_pkg::STS_EMPTY;
                end else begin
                    e_rd      = 1'b1;
                    e_rd_addr = a_last;
                    e_cls     = deq_pkg::CLS_READ;
                    e_cnt     = r_cnt - CW'(1);
                end
            end
            deq_pkg::MODE_READ_FRONT: begin
                if (empty) begin
                    e_status = deq_pkg::STS_EMPTY;
                end else begin
                    e_rd      = 1'b1;
                    e_rd_addr = r_head;
                    e_cls     = deq_pkg::CLS_READ;
                end
            end
            deq_pkg::MODE_READ_BACK: begin
                if (empty) begin
                    e_status = deq_pkg::STS_EMPTY;
                end else begin
                    e_rd      = 1'b1;
                    e_rd_addr = a_last;
                    e_cls     = deq_pkg::CLS_READ;
                end
            end
            deq_pkg::MODE_READ_AT: begin
                if (pos_ge) begin
                    e_status = deq_pkg::STS_RANGE;
                end else begin
                    e_rd      = 1'b1;
                    e_rd_addr = a_pos;
                    e_cls     = deq_pkg::CLS_READ;
                end
            end
            deq_pkg::MODE_INSERT_AT: begin
                if (pos_gt) begin
                    e_status = deq_pkg::STS_RANGE;
                end else if (full) begin
                    e_status = deq_pkg::STS_FULL;
                end else begin
                    e_cnt = r_cnt + CW'(1);
                    if (ins_front) begin
                        e_head  = a_hm1;
                        e_src   = r_head;
                        e_up    = 1'b1;
                        e_left  = pos_c;
                        e_vaddr = a_posm1;
                    end else begin
                        e_src   = a_last;
                        e_up    = 1'b0;
                        e_left  = r_cnt - pos_c;
                        e_vaddr = a_pos;
                    end
                    e_cls = (e_left == '0) ? deq_pkg::CLS_VAL : deq_pkg::CLS_SHIFT;
                end
            end
            deq_pkg::MODE_ERASE_AT: begin
                if (pos_ge) begin
                    e_status = deq_pkg::STS_RANGE;
                end else begin
                    e_cnt = r_cnt - CW'(1);
                    if (ers_front) begin
                        e_head = a_hp1;
                        e_src  = a_posm1;
                        e_up   = 1'b0;
                        e_left = pos_c;
                    end else begin
                        e_src  = a_posp1;
                        e_up   = 1'b1;
                        e_left = r_cnt - pos_c - CW'(1);
                    end
                    e_cls = (e_left == '0) ? deq_pkg::CLS_DONE : deq_pkg::CLS_SHIFT;
                end
            end
            deq_pkg::MODE_CLEAR: begin
                e_head = '0;
                e_cnt  = '0;
            end
            default: begin
                e_status = deq_pkg::STS_OK;
            end
        endcase
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_dst;
        ram_wr_data = ram_rd_data;
        if (i_cmd.exec && e_wr) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = e_wr_addr;
            ram_wr_data = r_val;
        end else if ((i_cmd.shift && r_pend) || i_cmd.drain) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_dst;
            ram_wr_data = ram_rd_data;
        end else if (i_cmd.wrval) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_vaddr;
            ram_wr_data = r_val;
        end
    end

    assign ram_rd_en   = (i_cmd.exec && e_rd) || i_cmd.shift;
    assign ram_rd_addr = i_cmd.shift ? r_src : e_rd_addr;

    deq_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_head = i_cmd.exec ? e_head : r_head;
        n_cnt  = i_cmd.exec ? e_cnt : r_cnt;
        n_pend = r_pend;
        if (i_cmd.exec) begin
            n_pend = 1'b0;
        end else if (i_cmd.shift) begin
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_pos  <= i_position;
            r_val  <= WIDTH'(i_item_value);
        end
        if (i_cmd.exec) begin
            r_src        <= e_src;
            r_up         <= e_up;
            r_left       <= e_left;
            r_vaddr      <= e_vaddr;
            r_res_status <= e_status;
            r_res_rd     <= '0;
        end
        if (i_cmd.shift) begin
            r_src  <= r_up ? f_inc(r_src) : f_dec(r_src);
            r_dst  <= r_up ? f_dec(r_src) : f_inc(r_src);
            r_left <= r_left - CW'(1);
        end
        if (i_cmd.rdcap) begin
            r_res_rd <= 32'(ram_rd_data);
        end
        if (i_cmd.load) begin
            r_out_rd     <= r_res_rd;
            r_out_status <= r_res_status;
            r_out_cnt    <= 7'(r_cnt);
            r_out_empty  <= (r_cnt == '0);
        end
    end

    assign o_sts.cls  = e_cls;
    assign o_sts.last = (r_left == CW'(1));
    assign o_sts.ins  = (r_mode == deq_pkg::MODE_INSERT_AT);

    assign o_read_value = r_out_rd;
    assign o_status     = r_out_status;
    assign o_count      = r_out_cnt;
    assign o_is_empty   = r_out_empty;

endmodule

>>> verif/tb_double_ended_queue_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended queue engine with a queue-based predictor.
module tb_double_ended_queue_engine;
    import deq_pkg::*;

    localparam int DEQ_DEPTH      = 64;
    localparam int DEQ_WIDTH      = 32;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int REPORT_LIMIT   = 10;

    localparam t_mode MODE_UNUSED_FIRST = MODE_CLEAR + 4'd1;
    localparam t_mode MODE_UNUSED_LAST  = 4'hF;

    typedef struct {
        logic [31:0] read_value;
        t_status     status;
        logic [6:0]  count;
        logic        is_empty;
    } t_deq_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_mode;
    logic [6:0]  i_position;
    logic [31:0] i_item_value;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_read_value;
    logic [1:0]  o_status;
    logic [6:0]  o_count;
    logic        o_is_empty;

    logic [31:0] deq_shadow[$];
    t_deq_result expected_results[$];
    int          fail_count = 0;
    int          quiet_cycles = 0;
    bit          sender_idle_on = 1'b1;
    bit          stall_idle_on = 1'b1;
    int          hold_req_cnt = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          burst_left = 0;

    double_ended_queue_engine #(
        .DEPTH(DEQ_DEPTH),
        .WIDTH(DEQ_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_position  (i_position),
        .i_item_value(i_item_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_read_value(o_read_value),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_deq_result predict_deq_op(t_mode mode, logic [6:0] pos,
                                                  logic [31:0] val);
        t_deq_result res;
        int          fill;
        int          idx;
        fill = deq_shadow.size();
        idx = int'(pos);
        res.read_value = '0;
        res.status = STS_OK;
        case (mode)
            MODE_PUSH_FRONT: begin
                if (fill >= DEQ_DEPTH) res.status = STS_FULL;
                else deq_shadow.push_front(val);
            end
            MODE_PUSH_BACK: begin
                if (fill >= DEQ_DEPTH) res.status = STS_FULL;
                else deq_shadow.push_back(val);
            end
            MODE_POP_FRONT: begin
                if (fill == 0) res.status = STS_EMPTY;
                else res.read_value = deq_shadow.pop_front();
            end
            MODE_POP_BACK: begin
                if (fill == 0) res.status = STS_EMPTY;
                else res.read_value = deq_shadow.pop_back();
            end
            MODE_READ_FRONT: begin
                if (fill == 0) res.status = STS_EMPTY;
                else res.read_value = deq_shadow[0];
            end
            MODE_READ_BACK: begin
                if (fill == 0) res.status = STS_EMPTY;
                else res.read_value = deq_shadow[fill - 1];
            end
            MODE_READ_AT: begin
                if (idx >= fill) res.status = STS_RANGE;
                else res.read_value = deq_shadow[idx];
            end
            MODE_INSERT_AT: begin
                if (idx > fill) res.status = STS_RANGE;
                else if (fill >= DEQ_DEPTH) res.status = STS_FULL;
                else deq_shadow.insert(idx, val);
            end
            MODE_ERASE_AT: begin
                if (idx >= fill) res.status = STS_RANGE;
                else deq_shadow.delete(idx);
            end
            MODE_CLEAR: begin
                deq_shadow.delete();
            end
            default: begin
            end
        endcase
        res.count = 7'(deq_shadow.size());
        res.is_empty = (deq_shadow.size() == 0);
        return res;
    endfunction

    task automatic send_op(input t_mode mode, input logic [6:0] pos, input logic [31:0] val);
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_position <= pos;
        i_item_value <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_results.push_back(predict_deq_op(mode, pos, val));
    endtask

    task automatic send_random_op(input int target);
        int          r;
        int          fill;
        int          pick;
        t_mode       mode;
        logic [6:0]  pos;
        logic [31:0] val;
        r = $urandom_range(0, 99);
        fill = deq_shadow.size();
        pick = $urandom_range(0, 2);
        if (r < 1) begin
            mode = MODE_CLEAR;
        end else if (r < 3) begin
            mode = t_mode'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
        end else if (r < 18) begin
            mode = (pick == 0) ? MODE_READ_FRONT : (pick == 1) ? MODE_READ_BACK : MODE_READ_AT;
        end else if (fill < target) begin
            mode = (pick == 0) ? MODE_PUSH_FRONT : (pick == 1) ? MODE_PUSH_BACK : MODE_INSERT_AT;
        end else begin
            mode = (pick == 0) ? MODE_POP_FRONT : (pick == 1) ? MODE_POP_BACK : MODE_ERASE_AT;
        end
        if ($urandom_range(0, 4) == 0) pos = 7'($urandom_range(0, 127));
        else pos = 7'($urandom_range(0, fill));
        r = $urandom_range(0, 19);
        if (r == 0) val = '0;
        else if (r == 1) val = '1;
        else val = $urandom;
        send_op(mode, pos, val);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        wait (expected_results.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic test_empty_queue();
        send_op(MODE_POP_FRONT, 7'd0, 32'h0);
        send_op(MODE_POP_BACK, 7'd0, 32'h0);
        send_op(MODE_READ_FRONT, 7'd0, 32'h0);
        send_op(MODE_READ_BACK, 7'd0, 32'h0);
        send_op(MODE_READ_AT, 7'd0, 32'h0);
        send_op(MODE_ERASE_AT, 7'd0, 32'h0);
        send_op(MODE_INSERT_AT, 7'd1, 32'h1234_5678);
        send_op(MODE_UNUSED_FIRST, 7'h7F, 32'hFFFF_FFFF);
        send_op(MODE_UNUSED_LAST, 7'd0, 32'h0);
    endtask

    task automatic test_end_ops();
        send_op(MODE_PUSH_BACK, 7'd0, 32'h0000_0000);
        send_op(MODE_PUSH_FRONT, 7'h7F, 32'hFFFF_FFFF);
        send_op(MODE_PUSH_BACK, 7'd0, 32'hA5A5_5A5A);
        send_op(MODE_READ_FRONT, 7'd0, 32'h0);
        send_op(MODE_READ_BACK, 7'd0, 32'h0);
        send_op(MODE_READ_AT, 7'd1, 32'h0);
        send_op(MODE_INSERT_AT, 7'd1, 32'h1111_2222);
        send_op(MODE_INSERT_AT, 7'd4, 32'h3333_4444);
        send_op(MODE_INSERT_AT, 7'd0, 32'h5555_6666);
        send_op(MODE_ERASE_AT, 7'd2, 32'h0);
        send_op(MODE_ERASE_AT, 7'd4, 32'h0);
        send_op(MODE_READ_AT, 7'h7F, 32'h0);
        send_op(MODE_POP_FRONT, 7'd0, 32'h0);
        send_op(MODE_POP_BACK, 7'd0, 32'h0);
        send_op(MODE_CLEAR, 7'd0, 32'h0);
        send_op(MODE_READ_FRONT, 7'd0, 32'h0);
    endtask

    task automatic test_capacity();
        repeat (DEQ_DEPTH / 2) send_op(MODE_PUSH_BACK, 7'd0, $urandom);
        repeat (DEQ_DEPTH / 2) send_op(MODE_PUSH_FRONT, 7'd0, $urandom);
        send_op(MODE_PUSH_BACK, 7'd0, 32'hDEAD_0001);
        send_op(MODE_PUSH_FRONT, 7'd0, 32'hDEAD_0002);
        send_op(MODE_INSERT_AT, 7'd10, 32'hDEAD_0003);
        send_op(MODE_INSERT_AT, 7'd64, 32'hDEAD_0004);
        send_op(MODE_INSERT_AT, 7'd65, 32'hDEAD_0005);
        send_op(MODE_READ_AT, 7'd63, 32'h0);
        send_op(MODE_READ_AT, 7'd64, 32'h0);
        send_op(MODE_ERASE_AT, 7'd32, 32'h0);
        send_op(MODE_ERASE_AT, 7'd0, 32'h0);
        send_op(MODE_ERASE_AT, 7'd61, 32'h0);
        send_op(MODE_READ_AT, 7'd61, 32'h0);
        send_op(MODE_INSERT_AT, 7'd31, 32'hBEEF_0001);
        send_op(MODE_INSERT_AT, 7'd40, 32'hBEEF_0002);
        send_op(MODE_INSERT_AT, 7'd2, 32'hBEEF_0003);
        send_op(MODE_READ_AT, 7'd31, 32'h0);
        send_op(MODE_CLEAR, 7'd0, 32'h0);
    endtask

    task automatic test_random_mix();
        int target;
        target = DEQ_DEPTH;
        for (int n = 0; n < 1600; n++) begin
            if (n % 150 == 0) begin
                case ((n / 150) % 3)
                    0: target = DEQ_DEPTH;
                    1: target = 0;
                    default: target = $urandom_range(1, DEQ_DEPTH - 1);
                endcase
            end
            send_random_op(target);
        end
    endtask

    task automatic test_backpressure();
        hold_req_cnt++;
        repeat (80) send_random_op(DEQ_DEPTH);
        wait_drained();
        repeat (40) send_random_op(0);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        sender_idle_on = 1'b0;
        stall_idle_on = 1'b0;
        for (int n = 0; n < 200; n++) send_random_op((n < 100) ? DEQ_DEPTH : 0);
    endtask

    always @(posedge i_clk) begin
        if (hold_req_cnt != hold_seen) begin
            hold_seen <= hold_req_cnt;
            hold_left <= LONG_HOLD - 1;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (burst_left > 0) begin
            burst_left <= burst_left - 1;
        end else if (stall_idle_on && $urandom_range(0, 2) == 0) begin
            i_stall <= 1'b1;
            burst_left <= $urandom_range(0, 11);
        end else begin
            i_stall <= 1'b0;
            burst_left <= stall_idle_on ? $urandom_range(0, 11) : 0;
        end
    end

    always @(posedge i_clk) begin
        t_deq_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                if (fail_count < REPORT_LIMIT)
                    $display("unexpected result beat: value=%h status=%0d count=%0d empty=%0b",
                             o_read_value, o_status, o_count, o_is_empty);
                fail_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_read_value !== exp_res.read_value || o_status !== exp_res.status ||
                    o_count !== exp_res.count || o_is_empty !== exp_res.is_empty) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $write("mismatch: exp value=%h status=%0d count=%0d empty=%0b, ",
                               exp_res.read_value, exp_res.status, exp_res.count,
                               exp_res.is_empty);
                        $display("got value=%h status=%0d count=%0d empty=%0b",
                                 o_read_value, o_status, o_count, o_is_empty);
                    end
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_stall <= 1'b0;
        i_mode <= MODE_CLEAR;
        i_position <= '0;
        i_item_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_queue();
        test_end_ops();
        test_capacity();
        test_random_mix();
        test_backpressure();
        test_back_to_back();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        fail_count += expected_results.size();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
